FILE: rtl/core/jse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_pkg: shared types and constants of the JSON string escaper
// Job descriptor passed from the classifier to the character serializer,
// body kinds, queue sizing and the ASCII codes the escaper emits.
// ----------------------------------------------------------------------------
package jse_pkg;

   // body kinds of a job
   localparam logic [2:0] KIND_NONE = 3'd0;  // quotes only
   localparam logic [2:0] KIND_CHAR = 3'd1;  // one char, optional backslash
   localparam logic [2:0] KIND_ESCU = 3'd2;  // bare \u of a lead byte
   localparam logic [2:0] KIND_UHEX = 3'd3;  // \u and four hex digits
   localparam logic [2:0] KIND_HEX4 = 3'd4;  // four hex digits
   localparam logic [2:0] KIND_SURR = 3'd5;  // surrogate pair tail

   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   localparam logic [6:0] CH_QUOTE     = 7'h22;
   localparam logic [6:0] CH_BACKSLASH = 7'h5C;
   localparam logic [6:0] CH_U         = 7'h75;
   localparam logic [6:0] CH_D         = 7'h64;

   typedef struct packed {
      logic        open_quote;
      logic        close_quote;
      logic [2:0]  kind;
      logic        esc;     // KIND_CHAR: emit a backslash first
      logic [19:0] data;    // char, 16-bit code unit or 20-bit surrogate offset
   } job_type;

endpackage

FILE: rtl/core/jse_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_front: byte classifier
// Tracks the open UTF-8 sequence and turns each accepted byte into a job
// descriptor for the serializer; bytes that emit nothing push no job.
// ----------------------------------------------------------------------------
module jse_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       in_byte,
   input  logic             first_of_string,
   input  logic             last_of_string,
   input  logic             empty_string,
   output logic             push,
   output jse_pkg::job_type job
);

   logic [7:0] lead_ff, lead_in;
   logic [7:0] second_ff, second_in;
   logic [7:0] third_ff, third_in;
   logic [1:0] pending_ff, pending_in;

   function automatic logic [1:0] seq_total(input logic [7:0] lead);
      if (lead < 8'hE0)
         return 2'd1;
      else if (lead < 8'hF0)
         return 2'd2;
      else
         return 2'd3;
   endfunction

   function automatic logic [6:0] short_letter(input logic [7:0] b);
      logic [6:0] ch;
      case (b)
         8'd8:    ch = 7'h62;  // b
         8'd9:    ch = 7'h74;  // t
         8'd10:   ch = 7'h6E;  // n
         8'd12:   ch = 7'h66;  // f
         8'd13:   ch = 7'h72;  // r
         default: ch = 7'h20;
      endcase
      return ch;
   endfunction

   always_comb begin
      logic [1:0]  pend;
      logic [1:0]  total;
      logic [20:0] uc;
      logic [20:0] offs;

      lead_in    = lead_ff;
      second_in  = second_ff;
      third_in   = third_ff;
      pending_in = pending_ff;
      job        = '0;
      pend       = first_of_string ? 2'd0 : pending_ff;
      total      = seq_total(lead_ff);
      uc         = {lead_ff[2:0], second_ff[5:0], third_ff[5:0], in_byte[5:0]};
      offs       = uc - 21'h10000;

      if (empty_string) begin
         pending_in      = 2'd0;
         job.open_quote  = 1'b1;
         job.close_quote = 1'b1;
      end else begin
         job.open_quote  = first_of_string;
         job.close_quote = last_of_string;
         pending_in      = pend;
         if (pend == 2'd0) begin
            if (in_byte >= 8'h20 && in_byte < 8'h7F) begin
               job.kind = jse_pkg::KIND_CHAR;
               job.esc  = (in_byte == 8'h5C) || (in_byte == 8'h22);
               job.data = {13'd0, in_byte[6:0]};
            end else if (in_byte >= 8'd8 && in_byte <= 8'd13 && in_byte != 8'd11) begin
               job.kind = jse_pkg::KIND_CHAR;
               job.esc  = 1'b1;
               job.data = {13'd0, short_letter(in_byte)};
            end else if (in_byte < 8'h80) begin
               job.kind = jse_pkg::KIND_UHEX;
               job.data = {12'd0, in_byte};
            end else begin
               job.kind   = jse_pkg::KIND_ESCU;
               lead_in    = in_byte;
               pending_in = seq_total(in_byte);
            end
         end else if (pend > 2'd1) begin
            // still collecting: first continuation goes to second_ff
            if (total == pend)
               second_in = in_byte;
            else
               third_in = in_byte;
            pending_in = pend - 2'd1;
         end else begin
            pending_in = 2'd0;
            if (total == 2'd1) begin
               job.kind = jse_pkg::KIND_HEX4;
               job.data = {9'd0, lead_ff[4:0], in_byte[5:0]};
            end else if (total == 2'd2) begin
               job.kind = jse_pkg::KIND_HEX4;
               job.data = {4'd0, lead_ff[3:0], second_ff[5:0], in_byte[5:0]};
            end else if (lead_ff < 8'hF5) begin
               job.kind = jse_pkg::KIND_SURR;
               job.data = offs[19:0];
            end
         end
         if (last_of_string)
            pending_in = 2'd0;
      end
   end

   assign push = accept &&
                 (job.open_quote || job.close_quote || job.kind != jse_pkg::KIND_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff    <= 8'd0;
         second_ff  <= 8'd0;
         third_ff   <= 8'd0;
         pending_ff <= 2'd0;
      end else if (accept) begin
         lead_ff    <= lead_in;
         second_ff  <= second_in;
         third_ff   <= third_in;
         pending_ff <= pending_in;
      end
   end

endmodule

FILE: rtl/core/jse_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_queue: job queue
// Short first-in first-out buffer of job descriptors between the classifier
// and the serializer; the head entry is visible without a pop.
// ----------------------------------------------------------------------------
module jse_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jse_pkg::job_type push_job,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output jse_pkg::job_type head_job
);

   jse_pkg::job_type entries_ff [jse_pkg::QueueDepth];
   logic [jse_pkg::QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [jse_pkg::QueuePtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [jse_pkg::QueueCntW-1:0] count_ff, count_in;

   assign full     = (count_ff == jse_pkg::QueueCntW'(jse_pkg::QueueDepth));
   assign empty    = (count_ff == '0);
   assign head_job = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push)
         entries_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("job queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("job queue read while empty");

endmodule

FILE: rtl/core/jse_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_back: character serializer
// Steps through the head job one character per cycle into the result register, while
// that register is free or being taken, and retires the job on its last character.
// ----------------------------------------------------------------------------
module jse_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_empty,
   input  jse_pkg::job_type job,
   output logic             job_pop,
   output logic [6:0]       out_char,
   output logic             last_char,
   output logic             out_empty,
   input  logic             out_pop
);

   logic [3:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   logic [6:0] char_ff;
   logic       last_ff;

   logic [3:0] len;
   logic [3:0] total;
   logic [3:0] idx;
   logic [6:0] ch;
   logic       is_last;
   logic       out_ready;
   logic       fire;

   function automatic logic [6:0] hex_char(input logic [3:0] n);
      if (n < 4'd10)
         return 7'h30 + {3'd0, n};
      else
         return 7'h57 + {3'd0, n};
   endfunction

   function automatic logic [3:0] body_len(input logic [2:0] kind, input logic esc);
      logic [3:0] n;
      case (kind)
         jse_pkg::KIND_CHAR: n = esc ? 4'd2 : 4'd1;
         jse_pkg::KIND_ESCU: n = 4'd2;
         jse_pkg::KIND_UHEX: n = 4'd6;
         jse_pkg::KIND_HEX4: n = 4'd4;
         jse_pkg::KIND_SURR: n = 4'd10;
         default:            n = 4'd0;
      endcase
      return n;
   endfunction

   function automatic logic [6:0] hex4_char(input logic [15:0] v, input logic [1:0] pos);
      logic [3:0] nib;
      case (pos)
         2'd0:    nib = v[15:12];
         2'd1:    nib = v[11:8];
         2'd2:    nib = v[7:4];
         default: nib = v[3:0];
      endcase
      return hex_char(nib);
   endfunction

   function automatic logic [6:0] body_char(input jse_pkg::job_type j, input logic [3:0] i);
      logic [6:0] c;
      logic [3:0] k;
      k = i - 4'd2;
      c = jse_pkg::CH_QUOTE;
      case (j.kind)
         jse_pkg::KIND_CHAR: c = (j.esc && i == 4'd0) ? jse_pkg::CH_BACKSLASH : j.data[6:0];
         jse_pkg::KIND_ESCU: c = (i == 4'd0) ? jse_pkg::CH_BACKSLASH : jse_pkg::CH_U;
         jse_pkg::KIND_UHEX: begin
            if (i == 4'd0)
               c = jse_pkg::CH_BACKSLASH;
            else if (i == 4'd1)
               c = jse_pkg::CH_U;
            else
               c = hex4_char(j.data[15:0], k[1:0]);
         end
         jse_pkg::KIND_HEX4: c = hex4_char(j.data[15:0], i[1:0]);
         jse_pkg::KIND_SURR: begin
            case (i)
               4'd0:    c = jse_pkg::CH_D;
               4'd1:    c = hex_char({2'b10, j.data[19:18]});
               4'd2:    c = hex_char(j.data[17:14]);
               4'd3:    c = hex_char(j.data[13:10]);
               4'd4:    c = jse_pkg::CH_BACKSLASH;
               4'd5:    c = jse_pkg::CH_U;
               4'd6:    c = jse_pkg::CH_D;
               4'd7:    c = hex_char({2'b11, j.data[9:8]});
               4'd8:    c = hex_char(j.data[7:4]);
               default: c = hex_char(j.data[3:0]);
            endcase
         end
         default: c = jse_pkg::CH_QUOTE;
      endcase
      return c;
   endfunction

   always_comb begin
      len   = body_len(job.kind, job.esc);
      total = {3'd0, job.open_quote} + len + {3'd0, job.close_quote};
      idx   = step_ff - {3'd0, job.open_quote};
      if (job.open_quote && step_ff == 4'd0)
         ch = jse_pkg::CH_QUOTE;
      else if (idx < len)
         ch = body_char(job, idx);
      else
         ch = jse_pkg::CH_QUOTE;
      is_last   = (step_ff == total - 4'd1);
      out_ready = !valid_ff || out_pop;
      fire      = !job_empty && out_ready;
      job_pop   = fire && is_last;
      if (fire)
         step_in = is_last ? 4'd0 : step_ff + 4'd1;
      else
         step_in = step_ff;
      if (fire)
         valid_in = 1'b1;
      else if (out_pop)
         valid_in = 1'b0;
      else
         valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 4'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   // hold the word until it is taken
   always_ff @(posedge clock) begin
      if (fire) begin
         char_ff <= ch;
         last_ff <= is_last;
      end
   end

   assign out_char  = char_ff;
   assign last_char = last_ff;
   assign out_empty = !valid_ff;

   a_step_in_job: assert property (@(posedge clock) disable iff (reset)
      !job_empty |-> (step_ff < total))
      else $error("serializer step beyond end of job");

   a_step_idle: assert property (@(posedge clock) disable iff (reset)
      job_empty |-> (step_ff == 4'd0))
      else $error("serializer step left open with no job");

endmodule

FILE: rtl/core/json_string_escaper.sv
`timescale 1ns / 1ps
// An accepted byte is written into the job queue; its first character is then registered
// in the result word. Throughput: one byte per cycle while the queue is not full; a byte
// yielding n characters (up to 12) holds its job at the queue head until all are emitted.
// The one-character-per-cycle serializer sets the rate; a 4-deep job queue absorbs bursts.
// Reset (synchronous): closes any open sequence and empties the queue and result word.
// ----------------------------------------------------------------------------
// json_string_escaper: UTF-8 to quoted JSON string text
// Classifies each input byte into an escape job, queues it, and serializes
// the job into ASCII characters on the result port.
// ----------------------------------------------------------------------------
module json_string_escaper (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] req_in_byte,
   input  logic       req_first_of_string,
   input  logic       req_last_of_string,
   input  logic       req_empty_string,
   input  logic       req_push,
   output logic       req_full,
   output logic [6:0] rsp_out_char,
   output logic       rsp_last_char,
   output logic       rsp_empty,
   input  logic       rsp_pop
);

   logic             accept;
   logic             job_push;
   jse_pkg::job_type new_job;
   jse_pkg::job_type head_job;
   logic             q_full;
   logic             q_empty;
   logic             q_pop;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   jse_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .in_byte         (req_in_byte),
      .first_of_string (req_first_of_string),
      .last_of_string  (req_last_of_string),
      .empty_string    (req_empty_string),
      .push            (job_push),
      .job             (new_job)
   );

   jse_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (new_job),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head_job (head_job)
   );

   jse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (q_empty),
      .job       (head_job),
      .job_pop   (q_pop),
      .out_char  (rsp_out_char),
      .last_char (rsp_last_char),
      .out_empty (rsp_empty),
      .out_pop   (rsp_pop)
   );

endmodule
